[hdl/playfair_digraph_cipher_unit_macros.svh]
// Assertion macros shared by the cipher unit RTL.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_UNIT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_UNIT_MACROS_SVH

// Check that post holds in the same cycle as pre.
`define PFC_ASSERT_SAME(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check that post holds in the cycle after pre.
`define PFC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[hdl/pfc_pkg.sv]
// Shared types, constants and square lookup functions for the cipher unit.
package pfc_pkg;

   typedef logic [4:0] letter_type;
   typedef logic [2:0] idx_type;
   typedef letter_type [0:4] row_type;
   typedef row_type [0:4] square_type;

   typedef struct packed {
      idx_type row;
      idx_type col;
   } pos_type;

   localparam letter_type LETTER_X = 5'd23;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_I = 5'd8;
   localparam int unsigned SIDE = 5;
   localparam int unsigned CELLS = SIDE * SIDE;

   localparam int unsigned MODE_W = 1;
   localparam int unsigned SQUARE_A_W = 45;
   localparam int unsigned SQUARE_B_W = 40;
   localparam int unsigned SQUARE_C_W = 40;
   localparam int unsigned SQUARE_A_CELLS = 9;
   localparam int unsigned SQUARE_B_CELLS = 8;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 5;

   typedef enum logic [1:0] {
      CSR_MODE,
      CSR_SQUARE_A,
      CSR_SQUARE_B,
      CSR_SQUARE_C
   } csr_index_type;

   // Find a letter in the square; first hit in row-major order, else row 0 column 0.
   function automatic pos_type pfc_locate(square_type sq, letter_type ch);
      pos_type p;
      p.row = '0;
      p.col = '0;
      for (int r = SIDE - 1; r >= 0; r--) begin
         for (int c = SIDE - 1; c >= 0; c--) begin
            if (sq[r][c] == ch) begin
               p.row = idx_type'(r);
               p.col = idx_type'(c);
            end
         end
      end
      return p;
   endfunction

   // Step a row or column by one, forward or back when dec is set, wrapping around the square.
   function automatic idx_type pfc_step(idx_type v, logic dec);
      idx_type r;
      if (dec) begin
         r = (v == '0) ? idx_type'(SIDE - 1) : v - idx_type'(1);
      end else begin
         r = (v == idx_type'(SIDE - 1)) ? '0 : v + idx_type'(1);
      end
      return r;
   endfunction

endpackage

[hdl/pfc_if.sv]
// Request and result channel interfaces of the cipher unit.
interface pfc_req_if;
   logic                valid;
   logic                ready;
   pfc_pkg::letter_type letter;
   logic                msg_end;

   modport source (output valid, letter, msg_end, input ready);
   modport sink (input valid, letter, msg_end, output ready);
endinterface

interface pfc_rsp_if;
   logic                valid;
   logic                ready;
   pfc_pkg::letter_type out_letter;
   logic                run_last;
   logic                msg_done;

   modport source (output valid, out_letter, run_last, msg_done, input ready);
   modport sink (input valid, out_letter, run_last, msg_done, output ready);
endinterface

[hdl/pfc_pair_cipher.sv]
// Combinational Playfair cipher of one letter pair against the key square.
module pfc_pair_cipher (
   input  pfc_pkg::square_type sq,
   input  pfc_pkg::letter_type first,
   input  pfc_pkg::letter_type second,
   input  logic                dec,
   output pfc_pkg::letter_type out1,
   output pfc_pkg::letter_type out2
);

   pfc_pkg::pos_type p1;
   pfc_pkg::pos_type p2;

   assign p1 = pfc_pkg::pfc_locate(sq, first);
   assign p2 = pfc_pkg::pfc_locate(sq, second);

   always_comb begin
      if (p1.row == p2.row) begin
         out1 = sq[p1.row][pfc_pkg::pfc_step(p1.col, dec)];
         out2 = sq[p2.row][pfc_pkg::pfc_step(p2.col, dec)];
      end else if (p1.col == p2.col) begin
         out1 = sq[pfc_pkg::pfc_step(p1.row, dec)][p1.col];
         out2 = sq[pfc_pkg::pfc_step(p2.row, dec)][p2.col];
      end else begin
         // rectangle: swap columns
         out1 = sq[p1.row][p2.col];
         out2 = sq[p2.row][p1.col];
      end
   end

endmodule

[hdl/playfair_digraph_cipher_unit.sv]
// Playfair digraph cipher unit: pair tracking, cipher stage and result drain.
// A request is registered in the stage register, then ciphered into the result register
// once that is empty or emptying. Throughput: one request per cycle when it yields at
// most one result and the result side is ready; results leave one per cycle from a
// four-slot result register while ready is held, and a larger set holds the stage.
// Reset (synchronous, active high) clears the registers, held letter and queues.
`include "playfair_digraph_cipher_unit_macros.svh"

module playfair_digraph_cipher_unit (
   input  logic                                clock,
   input  logic                                reset,
   pfc_req_if.sink                             req_chan,
   pfc_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pfc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pfc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // Stage register: the pairs a request completes, ready for the cipher logic.
   typedef struct packed {
      pfc_pkg::letter_type first;
      pfc_pkg::letter_type second;
      pfc_pkg::letter_type pad_letter;
      logic                has_pair;
      logic                has_pad;
      logic                dec;
      logic                msg_end;
   } stage_type;

   typedef pfc_pkg::letter_type [0:3] slots_type;

   // ---------------- configuration registers ----------------
   logic                              mode_ff;
   logic [pfc_pkg::SQUARE_A_W-1:0]    square_a_ff;
   logic [pfc_pkg::SQUARE_B_W-1:0]    square_b_ff;
   logic [pfc_pkg::SQUARE_C_W-1:0]    square_c_ff;
   logic                              csr_write;
   pfc_pkg::csr_index_type            csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // registers sit at 8-byte strides; the low address bits are ignored
   assign csr_index  = pfc_pkg::csr_index_type'(csr_paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         square_a_ff <= '0;
         square_b_ff <= '0;
         square_c_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            pfc_pkg::CSR_MODE:     mode_ff     <= csr_pwdata[0];
            pfc_pkg::CSR_SQUARE_A: square_a_ff <= csr_pwdata[pfc_pkg::SQUARE_A_W-1:0];
            pfc_pkg::CSR_SQUARE_B: square_b_ff <= csr_pwdata[pfc_pkg::SQUARE_B_W-1:0];
            pfc_pkg::CSR_SQUARE_C: square_c_ff <= csr_pwdata[pfc_pkg::SQUARE_C_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register, zero-extended to the bus width.
   always_comb begin
      case (csr_index)
         pfc_pkg::CSR_MODE:     csr_prdata = pfc_pkg::CSR_DATA_W'(mode_ff);
         pfc_pkg::CSR_SQUARE_A: csr_prdata = pfc_pkg::CSR_DATA_W'(square_a_ff);
         pfc_pkg::CSR_SQUARE_B: csr_prdata = pfc_pkg::CSR_DATA_W'(square_b_ff);
         pfc_pkg::CSR_SQUARE_C: csr_prdata = pfc_pkg::CSR_DATA_W'(square_c_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // Unpack the three square registers into a 5x5 grid, cell k at row k/5.
   pfc_pkg::square_type square;

   for (genvar k = 0; k < pfc_pkg::CELLS; k++) begin : g_cell
      localparam int R = k / pfc_pkg::SIDE;
      localparam int C = k % pfc_pkg::SIDE;
      localparam int KB = k - pfc_pkg::SQUARE_A_CELLS;
      localparam int KC = KB - pfc_pkg::SQUARE_B_CELLS;
      if (k < pfc_pkg::SQUARE_A_CELLS) begin : g_a
         assign square[R][C] = square_a_ff[5*k +: 5];
      end else if (KB < pfc_pkg::SQUARE_B_CELLS) begin : g_b
         assign square[R][C] = square_b_ff[5*KB +: 5];
      end else begin : g_c
         assign square[R][C] = square_c_ff[5*KC +: 5];
      end
   end

   // ---------------- request side: pair tracking ----------------
   logic                held_valid_ff;
   logic                held_valid_in;
   pfc_pkg::letter_type held_letter_ff;
   pfc_pkg::letter_type held_letter_in;
   logic                stage_valid_ff;
   logic                stage_valid_in;
   stage_type           stage_ff;
   stage_type           stage_in;
   logic                req_accept;
   logic                stage_load;

   pfc_pkg::letter_type ch;
   logic                held_hit;
   logic                next_valid;
   pfc_pkg::letter_type next_letter;

   assign req_accept = req_chan.valid & req_chan.ready;
   assign req_chan.ready = !stage_valid_ff || stage_load;

   always_comb begin
      // fold J onto I before anything else sees the letter
      ch = (req_chan.letter == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : req_chan.letter;
      held_hit = held_valid_ff && (ch == held_letter_ff) && !mode_ff;

      // Open pair: the held letter plus this one, or plus X when doubled in encrypt.
      stage_in.first      = held_letter_ff;
      stage_in.second     = held_hit ? pfc_pkg::LETTER_X : ch;
      stage_in.has_pair   = held_valid_ff;
      stage_in.dec        = mode_ff;
      stage_in.msg_end    = req_chan.msg_end;

      // What remains held once this letter is taken; a doubled letter carries on.
      next_valid  = held_valid_ff ? held_hit : 1'b1;
      next_letter = held_valid_ff ? held_letter_ff : ch;

      // A lone letter at message end is padded with X in encrypt, dropped in decrypt.
      stage_in.has_pad    = !mode_ff && req_chan.msg_end && next_valid;
      stage_in.pad_letter = next_letter;

      held_valid_in  = req_chan.msg_end ? 1'b0 : next_valid;
      held_letter_in = req_chan.msg_end ? '0 : next_letter;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff  <= 1'b0;
         held_letter_ff <= '0;
      end else if (req_accept) begin
         held_valid_ff  <= held_valid_in;
         held_letter_ff <= held_letter_in;
      end
   end

   assign stage_valid_in = req_accept ? 1'b1 : (stage_load ? 1'b0 : stage_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
   end

   // ---------------- cipher logic between stage and result registers ----------------
   pfc_pkg::letter_type pair_out1;
   pfc_pkg::letter_type pair_out2;
   pfc_pkg::letter_type pad_out1;
   pfc_pkg::letter_type pad_out2;

   pfc_pair_cipher u_pair_cipher (
      .sq     (square),
      .first  (stage_ff.first),
      .second (stage_ff.second),
      .dec    (stage_ff.dec),
      .out1   (pair_out1),
      .out2   (pair_out2)
   );

   pfc_pair_cipher u_pad_cipher (
      .sq     (square),
      .first  (stage_ff.pad_letter),
      .second (pfc_pkg::LETTER_X),
      .dec    (1'b0),
      .out1   (pad_out1),
      .out2   (pad_out2)
   );

   // ---------------- result register: four slots drained in order ----------------
   slots_type  slots_ff;
   slots_type  slots_in;
   logic [3:0] mask_ff;
   logic [3:0] mask_in;
   logic [3:0] load_mask;
   logic [3:0] mask_rest;
   logic       done_ff;
   logic       done_in;
   logic       rsp_pop;
   logic       slot_last;
   logic [1:0] slot_sel;

   always_comb begin
      // slots 0-1 hold the pair, 2-3 the pad; decrypt drops any X it yields
      load_mask[0] = stage_ff.has_pair &&
                     !(stage_ff.dec && (pair_out1 == pfc_pkg::LETTER_X));
      load_mask[1] = stage_ff.has_pair &&
                     !(stage_ff.dec && (pair_out2 == pfc_pkg::LETTER_X));
      load_mask[2] = stage_ff.has_pad;
      load_mask[3] = stage_ff.has_pad;
   end

   assign rsp_pop    = rsp_chan.valid & rsp_chan.ready;
   assign mask_rest  = mask_ff & (mask_ff - 4'd1);
   assign slot_last  = (mask_rest == '0);
   // take the next stage item once the current result set is empty or leaving
   assign stage_load = stage_valid_ff && ((mask_ff == '0) || (rsp_pop && slot_last));

   always_comb begin
      slots_in = slots_ff;
      done_in  = done_ff;
      mask_in  = mask_ff;
      if (stage_load) begin
         slots_in = {pair_out1, pair_out2, pad_out1, pad_out2};
         done_in  = stage_ff.msg_end;
         mask_in  = load_mask;
      end else if (rsp_pop) begin
         mask_in  = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      done_ff  <= done_in;
   end

   // present the lowest occupied slot
   always_comb begin
      if (mask_ff[0]) begin
         slot_sel = 2'd0;
      end else if (mask_ff[1]) begin
         slot_sel = 2'd1;
      end else if (mask_ff[2]) begin
         slot_sel = 2'd2;
      end else begin
         slot_sel = 2'd3;
      end
   end

   assign rsp_chan.valid      = (mask_ff != '0);
   assign rsp_chan.out_letter = slots_ff[slot_sel];
   assign rsp_chan.run_last   = slot_last;
   assign rsp_chan.msg_done   = done_ff;

   // ---------------- assertions ----------------
   `PFC_ASSERT_NEXT(a_end_clears_held, req_accept && req_chan.msg_end, !held_valid_ff, "held letter survives message end")
   `PFC_ASSERT_SAME(a_dec_two_max, stage_load && stage_ff.dec, $countones(load_mask) <= 2, "decrypt request loads more than one pair")
   `PFC_ASSERT_SAME(a_enc_whole_pairs, stage_load && !stage_ff.dec, $countones(load_mask) == 0 || $countones(load_mask) == 2 || $countones(load_mask) == 4, "encrypt request loads a partial pair")
   `PFC_ASSERT_NEXT(a_last_empties, rsp_pop && rsp_chan.run_last && !stage_valid_ff, !rsp_chan.valid, "result shown after last of a request")
   `PFC_ASSERT_SAME(a_dec_no_x, rsp_chan.valid && mode_ff && !stage_valid_ff && !stage_ff.has_pad && (mask_ff[2] == 1'b0), rsp_chan.out_letter != pfc_pkg::LETTER_X || !stage_ff.dec, "decrypt result is X")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the Playfair cipher unit: scripted and random requests.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pfc_pkg::*;

   localparam int SQ = SIDE;
   localparam int NCELLS = CELLS;
   localparam int DRAIN_LIMIT = 20000;
   // Margin for the block to settle once every owed result is back.
   localparam int SETTLE_CYCLES = 8;

   typedef letter_type [0:24] key_cells_type;
   typedef letter_type [0:3] result_letters_type;

   typedef struct packed {
      letter_type out_letter;
      logic       run_last;
      logic       msg_done;
   } cipher_result_type;

   typedef enum logic [1:0] {
      STEP_SEND,
      STEP_EXAMPLE_KEY,
      STEP_DECRYPT
   } step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      letter_type         ch;
      logic               fin;
      logic               typed;
      logic [2:0]         n_out;
      result_letters_type outs;
   } script_row_type;

   // Classic example square, row-major: PLAYF / IREXM / BCDGH / KNOQS / TUVWZ.
   localparam key_cells_type EXAMPLE_KEY = {
      5'd15, 5'd11, 5'd0,  5'd24, 5'd5,
      5'd8,  5'd17, 5'd4,  5'd23, 5'd12,
      5'd1,  5'd2,  5'd3,  5'd6,  5'd7,
      5'd10, 5'd13, 5'd14, 5'd16, 5'd18,
      5'd19, 5'd20, 5'd21, 5'd22, 5'd25
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pfc_req_if req_chan ();
   pfc_rsp_if rsp_chan ();

   playfair_digraph_cipher_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Predictor copy of the registers and the open pair.
   logic                  dec_mode;
   logic [SQUARE_A_W-1:0] key_a;
   logic [SQUARE_B_W-1:0] key_b;
   logic [SQUARE_C_W-1:0] key_c;
   letter_type            held_ch;
   logic                  held_ok;

   // Cipher letters still owed by the block, oldest first.
   cipher_result_type pending_letters[$];

   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int key_settings = 0;
   // Idling knobs, percent chance of a gap before a request / a stall on the result side.
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;

   // Scripted opening: reset defaults with typed results, then the example square.
   script_row_type script_rows [28] = '{
      // All-zero square after reset: every letter lands on row 0 column 0, every result is A.
      '{STEP_SEND, 5'd0,  1'b0, 1'b1, 3'd0, 20'd0},
      '{STEP_SEND, 5'd31, 1'b1, 1'b1, 3'd2, 20'd0},
      '{STEP_SEND, 5'd25, 1'b1, 1'b1, 3'd2, 20'd0},
      '{STEP_EXAMPLE_KEY, 5'd0, 1'b0, 1'b0, 3'd0, 20'd0},
      // same row, same column, rectangle
      '{STEP_SEND, 5'd15, 1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd0,  1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd11, 1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd17, 1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd7,  1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd8,  1'b0, 1'b0, 3'd0, 20'd0},
      // doubled letter split with X, second one carried into the next pair
      '{STEP_SEND, 5'd4,  1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd4,  1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd18, 1'b0, 1'b0, 3'd0, 20'd0},
      // J folds to I, so J then I at the end doubles and pads: four results
      '{STEP_SEND, 5'd9,  1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd8,  1'b1, 1'b0, 3'd0, 20'd0},
      // X doubled with X
      '{STEP_SEND, 5'd23, 1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd23, 1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd16, 1'b0, 1'b0, 3'd0, 20'd0},
      // letter outside the alphabet, alone at the end; then a plain lone final letter
      '{STEP_SEND, 5'd30, 1'b1, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd19, 1'b1, 1'b0, 3'd0, 20'd0},
      // leave D held across the switch to decrypt
      '{STEP_SEND, 5'd3,  1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_DECRYPT, 5'd0, 1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd6,  1'b0, 1'b0, 3'd0, 20'd0},
      // M,I deciphers to X,M: the X is dropped
      '{STEP_SEND, 5'd12, 1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd8,  1'b0, 1'b0, 3'd0, 20'd0},
      // lone final letter in decrypt gives nothing
      '{STEP_SEND, 5'd10, 1'b1, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd0,  1'b0, 1'b0, 3'd0, 20'd0},
      '{STEP_SEND, 5'd1,  1'b1, 1'b0, 3'd0, 20'd0}
   };

   function automatic letter_type key_cell(int k);
      if (k < SQUARE_A_CELLS) return key_a[5*k +: 5];
      if (k < SQUARE_A_CELLS + SQUARE_B_CELLS) return key_b[5*(k-SQUARE_A_CELLS) +: 5];
      return key_c[5*(k-SQUARE_A_CELLS-SQUARE_B_CELLS) +: 5];
   endfunction

   // First hit in row-major order; a missing letter sits at row 0 column 0.
   function automatic int key_find(letter_type ch);
      for (int k = 0; k < NCELLS; k++) begin
         if (key_cell(k) == ch) return k;
      end
      return 0;
   endfunction

   function automatic void cipher_pair(input letter_type a, input letter_type b,
                                       input logic dec, output letter_type o1,
                                       output letter_type o2);
      int p1, p2, r1, c1, r2, c2, d;
      p1 = key_find(a);
      p2 = key_find(b);
      r1 = p1 / SQ;
      c1 = p1 % SQ;
      r2 = p2 / SQ;
      c2 = p2 % SQ;
      d = dec ? SQ - 1 : 1;
      if (r1 == r2) begin
         o1 = key_cell(r1 * SQ + (c1 + d) % SQ);
         o2 = key_cell(r2 * SQ + (c2 + d) % SQ);
      end else if (c1 == c2) begin
         o1 = key_cell(((r1 + d) % SQ) * SQ + c1);
         o2 = key_cell(((r2 + d) % SQ) * SQ + c2);
      end else begin
         o1 = key_cell(r1 * SQ + c2);
         o2 = key_cell(r2 * SQ + c1);
      end
   endfunction

   // Advance the pair tracker by one letter and return the cipher letters it releases.
   function automatic void playfair_step(input letter_type raw, input logic fin,
                                         output result_letters_type outs, output int n);
      letter_type ch, o1, o2;
      logic       doubled;
      ch = (raw == LETTER_J) ? LETTER_I : raw;
      n = 0;
      outs = '0;
      if (dec_mode) begin
         if (held_ok) begin
            cipher_pair(held_ch, ch, 1'b1, o1, o2);
            if (o1 != LETTER_X) begin
               outs[n] = o1;
               n++;
            end
            if (o2 != LETTER_X) begin
               outs[n] = o2;
               n++;
            end
            held_ok = 1'b0;
         end else begin
            held_ch = ch;
            held_ok = 1'b1;
         end
      end else begin
         if (held_ok) begin
            // a doubled letter pairs with X and stays held
            doubled = (ch == held_ch);
            cipher_pair(held_ch, doubled ? LETTER_X : ch, 1'b0, o1, o2);
            outs[n] = o1;
            outs[n+1] = o2;
            n += 2;
            held_ok = doubled;
         end else begin
            held_ch = ch;
            held_ok = 1'b1;
         end
         if (fin && held_ok) begin
            cipher_pair(held_ch, LETTER_X, 1'b0, o1, o2);
            outs[n] = o1;
            outs[n+1] = o2;
            n += 2;
         end
      end
      if (fin) begin
         held_ok = 1'b0;
         held_ch = '0;
      end
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_mask(csr_index_type idx);
      case (idx)
         CSR_MODE:     return {CSR_DATA_W{1'b1}} >> (CSR_DATA_W - MODE_W);
         CSR_SQUARE_A: return {CSR_DATA_W{1'b1}} >> (CSR_DATA_W - SQUARE_A_W);
         CSR_SQUARE_B: return {CSR_DATA_W{1'b1}} >> (CSR_DATA_W - SQUARE_B_W);
         default:      return {CSR_DATA_W{1'b1}} >> (CSR_DATA_W - SQUARE_C_W);
      endcase
   endfunction

   function automatic key_cells_type shuffled_alphabet();
      key_cells_type cells;
      letter_type    t;
      int            j, n;
      n = 0;
      for (int k = 0; k < 26; k++) begin
         if (k != LETTER_J) begin
            cells[n] = letter_type'(k);
            n++;
         end
      end
      for (int k = NCELLS - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = cells[k];
         cells[k] = cells[j];
         cells[j] = t;
      end
      return cells;
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(5, 25);
      return $urandom_range(1, 3);
   endfunction

   // One APB transfer: idle cycle, setup, access. Drop the select at the end.
   task automatic csr_access(input csr_index_type idx, input logic wr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= CSR_ADDR_W'({idx, 3'b000});
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] want);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(idx, 1'b0, '0, rd);
      if ((rd & reg_mask(idx)) !== want) begin
         $error("%s readback: expected %h, got %h", idx.name(), want, rd & reg_mask(idx));
         errors++;
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      logic [CSR_DATA_W-1:0] kept, rd;
      kept = val & reg_mask(idx);
      csr_access(idx, 1'b1, kept, rd);
      case (idx)
         CSR_MODE:     dec_mode = kept[0];
         CSR_SQUARE_A: key_a = kept[SQUARE_A_W-1:0];
         CSR_SQUARE_B: key_b = kept[SQUARE_B_W-1:0];
         default:      key_c = kept[SQUARE_C_W-1:0];
      endcase
      check_reg(idx, kept);
   endtask

   task automatic program_key(logic m, logic [CSR_DATA_W-1:0] a, logic [CSR_DATA_W-1:0] b,
                              logic [CSR_DATA_W-1:0] c);
      write_reg(CSR_SQUARE_A, a);
      write_reg(CSR_SQUARE_B, b);
      write_reg(CSR_SQUARE_C, c);
      write_reg(CSR_MODE, CSR_DATA_W'(m));
      key_settings++;
   endtask

   // Pack 25 cells five bits apiece into the three square registers.
   task automatic load_square(logic m, key_cells_type cells);
      logic [CSR_DATA_W-1:0] a, b, c;
      a = '0;
      b = '0;
      c = '0;
      for (int k = 0; k < NCELLS; k++) begin
         if (k < SQUARE_A_CELLS)
            a[5*k +: 5] = cells[k];
         else if (k < SQUARE_A_CELLS + SQUARE_B_CELLS)
            b[5*(k-SQUARE_A_CELLS) +: 5] = cells[k];
         else
            c[5*(k-SQUARE_A_CELLS-SQUARE_B_CELLS) +: 5] = cells[k];
      end
      program_key(m, a, b, c);
   endtask

   // Hold requests off until every owed letter is back, then let the block settle.
   task automatic wait_drained();
      int spins;
      req_chan.valid <= 1'b0;
      spins = 0;
      while (pending_letters.size() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_letters.size() != 0) begin
         $error("%0d expected results never arrived", pending_letters.size());
         errors++;
         pending_letters.delete();
      end
   endtask

   // Present one request, wait for the handshake, then queue what it should release.
   // Keep valid high on return so back-to-back requests need no second assignment.
   task automatic send_request(letter_type ch, logic fin, logic typed, int n_typed,
                               result_letters_type typed_outs);
      result_letters_type outs;
      cipher_result_type  owed;
      int                 n, gap;
      gap = pick_gap(req_gap_pct);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.letter <= ch;
      req_chan.msg_end <= fin;
      do @(posedge clock); while (!req_chan.ready);
      playfair_step(ch, fin, outs, n);
      if (typed) begin
         outs = typed_outs;
         n = n_typed;
      end
      for (int k = 0; k < n; k++) begin
         owed.out_letter = outs[k];
         owed.run_last = (k == n - 1);
         owed.msg_done = fin;
         pending_letters.insert(pending_letters.size(), owed);
      end
      items_sent++;
   endtask

   // Random letters, weighted toward doubles, X and J; some outside the alphabet.
   task automatic run_random(int count, logic pressure);
      letter_type ch, prev;
      logic       fin;
      int         pick;
      prev = LETTER_X;
      for (int i = 0; i < count; i++) begin
         // pause the sender once until the block has fully drained
         if (pressure && i == count / 2) wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 12) ch = prev;
         else if (pick < 22) ch = LETTER_X;
         else if (pick < 27) ch = LETTER_J;
         else if (pick < 32) ch = letter_type'($urandom_range(26, 31));
         else ch = letter_type'($urandom_range(0, 25));
         fin = ($urandom_range(0, 7) == 0);
         send_request(ch, fin, 1'b0, 0, '0);
         prev = ch;
      end
   endtask

   // Result side: check every accepted result against the oldest owed letter,
   // and stall ready in runs, mostly short ones.
   initial begin
      int                stall_left;
      cipher_result_type want;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_chan.valid && rsp_chan.ready) begin
               if (pending_letters.size() == 0) begin
                  $error("unexpected result: out_letter %0d run_last %0b msg_done %0b",
                         rsp_chan.out_letter, rsp_chan.run_last, rsp_chan.msg_done);
                  errors++;
               end else begin
                  want = pending_letters.pop_front();
                  results_seen++;
                  if (rsp_chan.out_letter !== want.out_letter) begin
                     $error("out_letter: expected %0d, got %0d", want.out_letter,
                            rsp_chan.out_letter);
                     errors++;
                  end
                  if (rsp_chan.run_last !== want.run_last) begin
                     $error("run_last: expected %0b, got %0b", want.run_last,
                            rsp_chan.run_last);
                     errors++;
                  end
                  if (rsp_chan.msg_done !== want.msg_done) begin
                     $error("msg_done: expected %0b, got %0b", want.msg_done,
                            rsp_chan.msg_done);
                     errors++;
                  end
               end
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_chan.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                          : $urandom_range(0, 2);
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   // Stimulus: reset, scripted rows, then random phases over several key settings.
   initial begin
      script_row_type row;
      int             count;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.letter <= '0;
      req_chan.msg_end <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      dec_mode = 1'b0;
      key_a = '0;
      key_b = '0;
      key_c = '0;
      held_ch = '0;
      held_ok = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Registers come out of reset at zero.
      check_reg(CSR_MODE, '0);
      check_reg(CSR_SQUARE_A, '0);
      check_reg(CSR_SQUARE_B, '0);
      check_reg(CSR_SQUARE_C, '0);

      req_gap_pct = 30;
      rsp_stall_pct = 30;
      foreach (script_rows[i]) begin
         row = script_rows[i];
         case (row.kind)
            STEP_SEND: begin
               send_request(row.ch, row.fin, row.typed, row.n_out, row.outs);
            end
            STEP_EXAMPLE_KEY: begin
               wait_drained();
               load_square(1'b0, EXAMPLE_KEY);
            end
            default: begin
               // switch mode with a letter still held
               wait_drained();
               write_reg(CSR_MODE, CSR_DATA_W'(1));
            end
         endcase
      end

      for (int ph = 0; ph < 7; ph++) begin
         wait_drained();
         case (ph)
            0: begin
               // no idling on either side
               load_square(1'b0, shuffled_alphabet());
               req_gap_pct = 0;
               rsp_stall_pct = 0;
               count = 60;
            end
            1: begin
               load_square(1'b1, shuffled_alphabet());
               req_gap_pct = 25;
               rsp_stall_pct = 25;
               count = 50;
            end
            2: begin
               // raw square: duplicates and letters missing or out of range
               program_key(1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom});
               req_gap_pct = 40;
               rsp_stall_pct = 60;
               count = 40;
            end
            3: begin
               program_key(1'b1, '1, '1, '1);
               req_gap_pct = 10;
               rsp_stall_pct = 10;
               count = 20;
            end
            4: begin
               program_key(1'b0, '1, '1, '1);
               count = 20;
            end
            5: begin
               program_key(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom});
               req_gap_pct = 50;
               rsp_stall_pct = 40;
               count = 40;
            end
            default: begin
               load_square(1'b0, shuffled_alphabet());
               req_gap_pct = 30;
               rsp_stall_pct = 30;
               count = 50;
            end
         endcase
         run_random(count, ph == 6);
      end

      wait_drained();
      $display("covered %0d requests and %0d results over %0d key settings",
               items_sent, results_seen, key_settings);
      $display("both modes, zero and all-ones squares, doubles, padding and mid-pair mode change");
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #1000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
